FILE: rtl/rpwc_pkg.sv
package rpwc_pkg;

  // measurement widths
  localparam int COUNT_BITS     = 12;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = 20;
  localparam int W_W            = 13;
  localparam int POS_W          = 10;

  // fixed numbers of the calibration
  localparam int PULSE_BASE = 1000;
  localparam int CAL_MARGIN = 50;
  localparam int CAL_SPAN   = 1100;
  localparam int POS_MAX    = 1000;
  localparam int OFFSET_RST = 1000;
  localparam int W_MAX      = (1 << (W_W - 1)) - 1;
  localparam int W_MIN      = -(1 << (W_W - 1));

  // derived widths
  localparam int SAT_W     = (COUNT_BITS + 2 > W_W + 2) ? COUNT_BITS + 2 : W_W + 2;
  localparam int DIFF_W    = W_W + 1;
  localparam int PROD_W    = W_W + GAIN_W;
  localparam int SPAN_BITS = $clog2(CAL_SPAN + 1);
  localparam int DIV_W     = SPAN_BITS + GAIN_FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int QW        = (DIV_W > GAIN_W) ? DIV_W : GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [DIV_W-1:0]  DIVIDEND = DIV_W'(CAL_SPAN) << GAIN_FRAC_BITS;

  // item queue depth between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // input commands
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_LOAD   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CALIB  = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_GAIN   = 2'd2
  } cfg_idx_t;

  // work item handed from front to back (tick means falling edge)
  typedef struct packed {
    cmd_t                  op;
    logic signed [W_W-1:0] width;
  } q_entry_t;

  // configuration seen by the back end
  typedef struct packed {
    logic                  calib_mode;
    logic signed [W_W-1:0] preset_offset;
    logic [GAIN_W-1:0]     preset_gain;
  } cfg_t;

  // saturate a wide signed value to the width range
  function automatic logic signed [W_W-1:0] sat_w(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(W_MAX);
    lo = SAT_W'(W_MIN);
    if (v > hi) begin
      sat_w = W_W'(W_MAX);
    end else if (v < lo) begin
      sat_w = W_W'(W_MIN);
    end else begin
      sat_w = v[W_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/rpwc_queue.sv
module rpwc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rpwc_pkg::q_entry_t  push_data,
  input  logic                pop,
  output rpwc_pkg::q_entry_t  head,
  output logic                full,
  output logic                empty
);

  rpwc_pkg::q_entry_t                 mem_r [rpwc_pkg::Q_DEPTH];
  logic [rpwc_pkg::Q_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [rpwc_pkg::Q_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [rpwc_pkg::Q_CNT_W-1:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == rpwc_pkg::Q_CNT_W'(rpwc_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == rpwc_pkg::Q_PTR_W'(rpwc_pkg::Q_DEPTH - 1)) ? '0
                                                                            : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == rpwc_pkg::Q_PTR_W'(rpwc_pkg::Q_DEPTH - 1)) ? '0
                                                                            : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/rpwc_front.sv
module rpwc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [1:0]          command,
  input  logic                pin_level,
  output logic                push,
  output rpwc_pkg::q_entry_t  push_data
);

  localparam logic [rpwc_pkg::COUNT_BITS-1:0] CMAX = {rpwc_pkg::COUNT_BITS{1'b1}};

  rpwc_pkg::cmd_t                     cmd;
  logic                               pin_prev_r, pin_prev_nxt;
  logic [rpwc_pkg::COUNT_BITS-1:0]    count_r, count_nxt;
  logic signed [rpwc_pkg::SAT_W-1:0]  width_wide;

  assign cmd = rpwc_pkg::cmd_t'(command);

  // width of the finished pulse, before saturation
  assign width_wide = $signed(rpwc_pkg::SAT_W'(count_r)) - rpwc_pkg::SAT_W'(rpwc_pkg::PULSE_BASE);

  // classify the item: edge, finish, load or nothing
  always_comb begin
    pin_prev_nxt    = pin_prev_r;
    count_nxt       = count_r;
    push            = 1'b0;
    push_data.op    = cmd;
    push_data.width = rpwc_pkg::sat_w(width_wide);
    if (in_accept) begin
      case (cmd)
        rpwc_pkg::CMD_TICK: begin
          if (pin_level && !pin_prev_r) begin
            count_nxt    = rpwc_pkg::COUNT_BITS'(1);
            pin_prev_nxt = 1'b1;
          end else if (pin_level) begin
            if (count_r != CMAX) begin
              count_nxt = count_r + 1'b1;
            end
          end else if (pin_prev_r) begin
            pin_prev_nxt = 1'b0;
            push         = 1'b1;
          end
        end
        rpwc_pkg::CMD_FINISH: push = 1'b1;
        rpwc_pkg::CMD_LOAD:   push = 1'b1;
        default:              push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_prev_r <= 1'b0;
      count_r    <= '0;
    end else begin
      pin_prev_r <= pin_prev_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

FILE: rtl/rpwc_back.sv
module rpwc_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rpwc_pkg::cfg_t                      cfg,
  input  rpwc_pkg::q_entry_t                  head,
  input  logic                                q_empty,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rpwc_pkg::POS_W-1:0]          out_position,
  output logic signed [rpwc_pkg::W_W-1:0]     out_width
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FDIFF = 5'b00010,
    S_DIV   = 5'b00100,
    S_MUL   = 5'b01000,
    S_POS   = 5'b10000
  } state_t;

  localparam int PH_W = rpwc_pkg::PROD_W - rpwc_pkg::GAIN_FRAC_BITS;

  state_t                                 state_r, state_nxt;
  logic signed [rpwc_pkg::W_W-1:0]        wmin_r, wmin_nxt;
  logic signed [rpwc_pkg::W_W-1:0]        wmax_r, wmax_nxt;
  logic signed [rpwc_pkg::W_W-1:0]        offset_r, offset_nxt;
  logic [rpwc_pkg::GAIN_W-1:0]            gain_r, gain_nxt;
  logic signed [rpwc_pkg::W_W-1:0]        width_r, width_nxt;
  logic signed [rpwc_pkg::DIFF_W-1:0]     diff_r, diff_nxt;
  logic [rpwc_pkg::PROD_W-1:0]            prod_r, prod_nxt;
  logic                                   pzero_r, pzero_nxt;
  logic [rpwc_pkg::W_W-1:0]               divisor_r, divisor_nxt;
  logic [rpwc_pkg::W_W-1:0]               rem_r, rem_nxt;
  logic [rpwc_pkg::DIV_W-1:0]             quo_r, quo_nxt;
  logic [rpwc_pkg::DIV_CNT_W-1:0]         dcnt_r, dcnt_nxt;
  logic                                   oval_r, oval_nxt;
  logic [rpwc_pkg::POS_W-1:0]             opos_r, opos_nxt;
  logic signed [rpwc_pkg::W_W-1:0]        owid_r, owid_nxt;

  logic signed [rpwc_pkg::SAT_W-1:0]      min_plus;
  logic signed [rpwc_pkg::DIFF_W-1:0]     fdiff;
  logic [rpwc_pkg::W_W+1:0]               trial;
  logic [rpwc_pkg::DIV_W-1:0]             quo_step;
  logic [rpwc_pkg::QW-1:0]                quo_ext;
  logic [PH_W-1:0]                        pos_hi;
  logic                                   out_free;

  assign out_free     = !oval_r || out_ready;
  assign out_valid    = oval_r;
  assign out_position = opos_r;
  assign out_width    = owid_r;

  // arithmetic feeding the sequencer
  assign min_plus = $signed(rpwc_pkg::SAT_W'(wmin_r)) + rpwc_pkg::SAT_W'(rpwc_pkg::CAL_MARGIN);
  assign fdiff    = rpwc_pkg::DIFF_W'(wmax_r) - rpwc_pkg::DIFF_W'(offset_r);
  assign trial    = {1'b0, rem_r, quo_r[rpwc_pkg::DIV_W-1]} - {2'b00, divisor_r};
  assign quo_step = {quo_r[rpwc_pkg::DIV_W-2:0], ~trial[rpwc_pkg::W_W+1]};
  assign quo_ext  = rpwc_pkg::QW'(quo_step);
  assign pos_hi   = prod_r[rpwc_pkg::PROD_W-1:rpwc_pkg::GAIN_FRAC_BITS];

  // sequencer: edge items go through multiply and clamp, finish through the divider
  always_comb begin
    state_nxt   = state_r;
    wmin_nxt    = wmin_r;
    wmax_nxt    = wmax_r;
    offset_nxt  = offset_r;
    gain_nxt    = gain_r;
    width_nxt   = width_r;
    diff_nxt    = diff_r;
    prod_nxt    = prod_r;
    pzero_nxt   = pzero_r;
    divisor_nxt = divisor_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    dcnt_nxt    = dcnt_r;
    oval_nxt    = oval_r && !out_ready;
    opos_nxt    = opos_r;
    owid_nxt    = owid_r;
    pop         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head.op)
            rpwc_pkg::CMD_TICK: begin
              if (cfg.calib_mode) begin
                if (head.width > wmax_r) begin
                  wmax_nxt = head.width;
                end
                if (head.width < wmin_r) begin
                  wmin_nxt = head.width;
                end
              end
              width_nxt = head.width;
              diff_nxt  = rpwc_pkg::DIFF_W'(head.width) - rpwc_pkg::DIFF_W'(offset_r);
              state_nxt = S_MUL;
            end
            rpwc_pkg::CMD_FINISH: begin
              offset_nxt = rpwc_pkg::sat_w(min_plus);
              state_nxt  = S_FDIFF;
            end
            rpwc_pkg::CMD_LOAD: begin
              offset_nxt = cfg.preset_offset;
              gain_nxt   = cfg.preset_gain;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      S_FDIFF: begin
        if (fdiff <= 0) begin
          gain_nxt  = rpwc_pkg::GAIN_MAX;
          state_nxt = S_IDLE;
        end else begin
          divisor_nxt = fdiff[rpwc_pkg::W_W-1:0];
          rem_nxt     = '0;
          quo_nxt     = rpwc_pkg::DIVIDEND;
          dcnt_nxt    = rpwc_pkg::DIV_CNT_W'(rpwc_pkg::DIV_W - 1);
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        // one quotient bit a cycle
        if (!trial[rpwc_pkg::W_W+1]) begin
          rem_nxt = trial[rpwc_pkg::W_W-1:0];
        end else begin
          rem_nxt = {rem_r[rpwc_pkg::W_W-2:0], quo_r[rpwc_pkg::DIV_W-1]};
        end
        quo_nxt  = quo_step;
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          gain_nxt  = (quo_ext > rpwc_pkg::QW'(rpwc_pkg::GAIN_MAX)) ? rpwc_pkg::GAIN_MAX
                                                                    : quo_ext[rpwc_pkg::GAIN_W-1:0];
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        pzero_nxt = (diff_r <= 0);
        prod_nxt  = rpwc_pkg::PROD_W'(diff_r[rpwc_pkg::W_W-1:0]) * rpwc_pkg::PROD_W'(gain_r);
        state_nxt = S_POS;
      end
      S_POS: begin
        // clamp and hand over to the output register
        if (out_free) begin
          oval_nxt = 1'b1;
          owid_nxt = width_r;
          if (pzero_r) begin
            opos_nxt = '0;
          end else if (pos_hi > PH_W'(rpwc_pkg::POS_MAX)) begin
            opos_nxt = rpwc_pkg::POS_W'(rpwc_pkg::POS_MAX);
          end else begin
            opos_nxt = pos_hi[rpwc_pkg::POS_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wmin_r   <= rpwc_pkg::W_W'(rpwc_pkg::OFFSET_RST);
      wmax_r   <= '0;
      offset_r <= rpwc_pkg::W_W'(rpwc_pkg::OFFSET_RST);
      gain_r   <= rpwc_pkg::GAIN_RST;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wmin_r   <= wmin_nxt;
      wmax_r   <= wmax_nxt;
      offset_r <= offset_nxt;
      gain_r   <= gain_nxt;
      oval_r   <= oval_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    width_r   <= width_nxt;
    diff_r    <= diff_nxt;
    prod_r    <= prod_nxt;
    pzero_r   <= pzero_nxt;
    divisor_r <= divisor_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    dcnt_r    <= dcnt_nxt;
    opos_r    <= opos_nxt;
    owid_r    <= owid_nxt;
  end

endmodule

FILE: rtl/rc_pulse_width_calibrator_core.sv
// an accepted falling-edge tick reaches out_tvalid via queue, S_MUL, S_POS and output register
// throughput: up to one item per cycle is taken while the two-entry queue has room;
// the back end takes an edge through S_IDLE, S_MUL and S_POS, a load in S_IDLE and a finish
// calibration through S_IDLE, S_FDIFF and the one-bit-a-cycle divider S_DIV
// reset: rst_n is synchronous, active low; it empties the queue and output and restores
// offset 1000, gain 1.0, min 1000, max 0 and the preset registers
module rc_pulse_width_calibrator_core (
  input  logic        clk,
  input  logic        rst_n,
  // input item: [1:0] command, [2] pin_level, [7:3] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // result item: [9:0] position, [22:10] width, [23] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  rpwc_pkg::cfg_t                     cfg_r, cfg_nxt;
  rpwc_pkg::q_entry_t                 push_data;
  rpwc_pkg::q_entry_t                 head;
  logic                               q_push, q_pop, q_full, q_empty;
  logic                               in_accept;
  logic [rpwc_pkg::POS_W-1:0]         position;
  logic signed [rpwc_pkg::W_W-1:0]    width;

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tdata = {1'b0, width, position};

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (rpwc_pkg::cfg_idx_t'(cfg_index))
        rpwc_pkg::CFG_CALIB:  cfg_nxt.calib_mode    = cfg_data[0];
        rpwc_pkg::CFG_OFFSET: cfg_nxt.preset_offset = cfg_data[rpwc_pkg::W_W-1:0];
        rpwc_pkg::CFG_GAIN:   cfg_nxt.preset_gain   = cfg_data[rpwc_pkg::GAIN_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.calib_mode    <= 1'b0;
      cfg_r.preset_offset <= rpwc_pkg::W_W'(rpwc_pkg::OFFSET_RST);
      cfg_r.preset_gain   <= rpwc_pkg::GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pulse timing and item classification
  rpwc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .command   (in_tdata[1:0]),
    .pin_level (in_tdata[2]),
    .push      (q_push),
    .push_data (push_data)
  );

  // decoupling queue
  rpwc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // calibration and position arithmetic
  rpwc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_position (position),
    .out_width    (width)
  );

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("item pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("item popped from empty queue");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (position <= rpwc_pkg::POS_W'(rpwc_pkg::POS_MAX)))
    else $error("position beyond clamp");

endmodule

FILE: verif/rc_pulse_width_calibrator_core_tb.sv
`timescale 1ns / 1ps

// one servo reading as it leaves the block
typedef struct {
  logic [rpwc_pkg::POS_W-1:0]      pos;
  logic signed [rpwc_pkg::W_W-1:0] w;
} servo_reading_t;

// predicts servo readings from the accepted items and checks the block's output
class servo_scoreboard;
  // register copies
  logic                            calib_on;
  logic signed [rpwc_pkg::W_W-1:0] preset_off;
  logic [rpwc_pkg::GAIN_W-1:0]     preset_gain;

  // measurement and calibration state
  logic                            pin_was_high;
  logic [rpwc_pkg::COUNT_BITS-1:0] high_ticks;
  logic signed [rpwc_pkg::W_W-1:0] w_lo;
  logic signed [rpwc_pkg::W_W-1:0] w_hi;
  logic signed [rpwc_pkg::W_W-1:0] off_now;
  logic [rpwc_pkg::GAIN_W-1:0]     gain_now;

  servo_reading_t readings_due[$];
  int errors;
  int edges_seen;

  function new();
    calib_on     = 1'b0;
    preset_off   = rpwc_pkg::W_W'(rpwc_pkg::OFFSET_RST);
    preset_gain  = rpwc_pkg::GAIN_RST;
    pin_was_high = 1'b0;
    high_ticks   = '0;
    w_lo         = rpwc_pkg::W_W'(rpwc_pkg::OFFSET_RST);
    w_hi         = '0;
    off_now      = rpwc_pkg::W_W'(rpwc_pkg::OFFSET_RST);
    gain_now     = rpwc_pkg::GAIN_RST;
    errors       = 0;
    edges_seen   = 0;
  endfunction

  function int pending();
    return readings_due.size();
  endfunction

  function void set_reg(rpwc_pkg::cfg_idx_t idx, logic [19:0] d);
    case (idx)
      rpwc_pkg::CFG_CALIB:  calib_on = d[0];
      rpwc_pkg::CFG_OFFSET: preset_off = d[rpwc_pkg::W_W-1:0];
      rpwc_pkg::CFG_GAIN:   preset_gain = d[rpwc_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  function logic signed [rpwc_pkg::W_W-1:0] clip_width(longint v);
    if (v > rpwc_pkg::W_MAX) return rpwc_pkg::W_W'(rpwc_pkg::W_MAX);
    if (v < rpwc_pkg::W_MIN) return rpwc_pkg::W_W'(rpwc_pkg::W_MIN);
    return rpwc_pkg::W_W'(v);
  endfunction

  // offset from the smallest width, gain spreads the span over 1100 counts
  function void finish_calibration();
    longint span;
    longint q;
    off_now = clip_width(longint'(w_lo) + rpwc_pkg::CAL_MARGIN);
    span = longint'(w_hi) - longint'(off_now);
    if (span <= 0) begin
      gain_now = rpwc_pkg::GAIN_MAX;
    end else begin
      q = (longint'(rpwc_pkg::CAL_SPAN) << rpwc_pkg::GAIN_FRAC_BITS) / span;
      gain_now = (q > longint'(rpwc_pkg::GAIN_MAX)) ? rpwc_pkg::GAIN_MAX
                                                    : rpwc_pkg::GAIN_W'(q);
    end
  endfunction

  function logic [rpwc_pkg::POS_W-1:0] servo_position(logic signed [rpwc_pkg::W_W-1:0] w);
    longint diff;
    longint p;
    diff = longint'(w) - longint'(off_now);
    if (diff <= 0) return '0;
    p = (diff * longint'(gain_now)) >> rpwc_pkg::GAIN_FRAC_BITS;
    return (p > rpwc_pkg::POS_MAX) ? rpwc_pkg::POS_W'(rpwc_pkg::POS_MAX)
                                   : rpwc_pkg::POS_W'(p);
  endfunction

  // advance the prediction by one accepted item
  function void note_item(rpwc_pkg::cmd_t cmd, logic pin);
    servo_reading_t r;
    case (cmd)
      rpwc_pkg::CMD_FINISH: finish_calibration();
      rpwc_pkg::CMD_LOAD: begin
        off_now  = preset_off;
        gain_now = preset_gain;
      end
      rpwc_pkg::CMD_TICK: begin
        if (pin && !pin_was_high) begin
          high_ticks   = rpwc_pkg::COUNT_BITS'(1);
          pin_was_high = 1'b1;
        end else if (pin) begin
          if (high_ticks != {rpwc_pkg::COUNT_BITS{1'b1}}) high_ticks = high_ticks + 1'b1;
        end else if (pin_was_high) begin
          // falling edge closes the pulse
          pin_was_high = 1'b0;
          r.w = clip_width(longint'(high_ticks) - rpwc_pkg::PULSE_BASE);
          if (calib_on) begin
            if (r.w > w_hi) w_hi = r.w;
            if (r.w < w_lo) w_lo = r.w;
          end
          r.pos = servo_position(r.w);
          readings_due.push_back(r);
          edges_seen++;
        end
      end
      default: ;
    endcase
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task check_reading(logic [23:0] d);
    servo_reading_t r;
    logic [rpwc_pkg::POS_W-1:0]      got_pos;
    logic signed [rpwc_pkg::W_W-1:0] got_w;
    got_pos = d[rpwc_pkg::POS_W-1:0];
    got_w   = d[rpwc_pkg::POS_W+rpwc_pkg::W_W-1:rpwc_pkg::POS_W];
    if (readings_due.size() == 0) begin
      report($sformatf("unexpected reading pos %0d width %0d", got_pos, got_w));
    end else begin
      r = readings_due.pop_front();
      if (got_pos !== r.pos)
        report($sformatf("position %0d, wanted %0d (width %0d)", got_pos, r.pos, r.w));
      if (got_w !== r.w)
        report($sformatf("width %0d, wanted %0d", got_w, r.w));
    end
  endtask
endclass

module rc_pulse_width_calibrator_core_tb;

  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 145;
  localparam int PHASE_EDGES  = 8;
  localparam int SETTLE_TICKS = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  servo_scoreboard sb = new();
  bit quiet = 1'b0;
  int items_done = 0;

  rc_pulse_width_calibrator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // pulse length in high ticks, mostly short to keep the run brief
  function automatic int pick_pulse_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 30);
    return $urandom_range(31, 60);
  endfunction

  // one item on the input channel, entered and left at a falling edge
  task automatic push_item(rpwc_pkg::cmd_t cmd, logic pin);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {5'b0, pin, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(cmd, pin);
    items_done++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // rising edge, further high ticks, falling edge; rare stray commands inside
  task automatic send_pulse(int len);
    int i;
    push_item(rpwc_pkg::CMD_TICK, 1'b1);
    for (i = 1; i < len; i++) begin
      if ($urandom_range(0, 99) == 0)
        push_item(rpwc_pkg::cmd_t'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
      push_item(rpwc_pkg::CMD_TICK, 1'b1);
    end
    push_item(rpwc_pkg::CMD_TICK, 1'b0);
  endtask

  task automatic write_reg(rpwc_pkg::cfg_idx_t idx, logic [19:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold the sender until every reading is in, then let the back end drain
  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // receiver stalls
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reading(out_tdata);
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int p;
    int r;
    int edges_start;
    int items_start;
    logic signed [rpwc_pkg::W_W-1:0] off;
    logic [19:0] gain;
    logic calib;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: extreme presets, stray bits above the offset field
    write_reg(rpwc_pkg::CFG_CALIB, {19'($urandom_range(0, 'h7ffff)), 1'b1});
    write_reg(rpwc_pkg::CFG_OFFSET, 20'hff000);
    write_reg(rpwc_pkg::CFG_GAIN, 20'hfffff);
    push_item(rpwc_pkg::CMD_NONE, 1'b1);
    push_item(rpwc_pkg::CMD_TICK, 1'b0);
    // finish with min above max: divisor not positive
    push_item(rpwc_pkg::CMD_FINISH, 1'b0);
    send_pulse(1);
    // non-tick commands inside a pulse leave the pin history alone
    push_item(rpwc_pkg::CMD_TICK, 1'b1);
    push_item(rpwc_pkg::CMD_FINISH, 1'b1);
    push_item(rpwc_pkg::CMD_LOAD, 1'b0);
    push_item(rpwc_pkg::CMD_NONE, 1'b0);
    push_item(rpwc_pkg::CMD_TICK, 1'b1);
    push_item(rpwc_pkg::CMD_TICK, 1'b0);
    // presets give a clamped position
    send_pulse(2);
    push_item(rpwc_pkg::CMD_LOAD, 1'b1);
    push_item(rpwc_pkg::CMD_FINISH, 1'b0);
    send_pulse(3);
    drain();

    // random phases, each with its own register setting
    for (p = 0; p < N_PHASES; p++) begin
      quiet = (p == 3);
      case (p)
        0: begin
          off   = rpwc_pkg::W_W'(rpwc_pkg::W_MAX);
          gain  = '0;
          calib = 1'b0;
        end
        1: begin
          off   = rpwc_pkg::W_W'(rpwc_pkg::W_MIN);
          gain  = 20'hfffff;
          calib = 1'b1;
        end
        2: begin
          off   = rpwc_pkg::W_W'(rpwc_pkg::OFFSET_RST);
          gain  = rpwc_pkg::GAIN_RST;
          calib = 1'b1;
        end
        default: begin
          off   = rpwc_pkg::W_W'($urandom_range(0, 1200)) - rpwc_pkg::W_W'(600);
          gain  = 20'($urandom_range(0, 'hfffff));
          calib = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(rpwc_pkg::CFG_CALIB, {19'($urandom_range(0, 'h7ffff)), calib});
      write_reg(rpwc_pkg::CFG_OFFSET, {7'($urandom_range(0, 127)), off});
      write_reg(rpwc_pkg::CFG_GAIN, gain);

      edges_start = sb.edges_seen;
      items_start = items_done;
      while (items_done - items_start < PHASE_ITEMS ||
             sb.edges_seen - edges_start < PHASE_EDGES) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          repeat ($urandom_range(0, 2)) push_item(rpwc_pkg::CMD_TICK, 1'b0);
          send_pulse(pick_pulse_len());
        end else if (r < 86) begin
          push_item(rpwc_pkg::CMD_FINISH, 1'($urandom_range(0, 1)));
        end else if (r < 94) begin
          push_item(rpwc_pkg::CMD_LOAD, 1'($urandom_range(0, 1)));
        end else begin
          push_item(rpwc_pkg::CMD_NONE, 1'($urandom_range(0, 1)));
        end
      end
      drain();
    end

    quiet = 1'b0;
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
